### src/ats_pkg.sv
package ats_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam int REQ_W  = 3;
    localparam int WORD_W = 32;
    localparam int POS_W  = 7;
    localparam int MIDX_W = 6;
    localparam int STAT_W = 2;
    localparam int CNTF_W = 7;

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND  = 3'd0,
        REQ_SEARCH  = 3'd1,
        REQ_REPLACE = 3'd2,
        REQ_INSERT  = 3'd3,
        REQ_DELETE  = 3'd4
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_MOVE,
        S_PUT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [MIDX_W-1:0] match_index;
        logic              found;
        t_status           status;
        logic              last;
        logic [CNTF_W-1:0] entry_count;
        logic [CNTF_W-1:0] replaced_count;
    } t_res;

endpackage

### src/array_table_search_insert_delete.sv
// Ordered table of up to 64 signed 32-bit words in a RAM with one write and one
// read port, served one request at a time by a small sequencer around one compare
// unit. Append, unknown kinds and error results go straight to the final result.
// Search and replace walk the live entries, each with a RAM read, then a compare;
// search emits each match as it finds the next one, so a stalled output lengthens
// the walk. Insert and delete move one entry at a time (read, write back). The
// input is stalled for the whole request; the finished result sits in an output
// register.
module array_table_search_insert_delete (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [ats_pkg::REQ_W-1:0]          i_req_type,
    input  logic signed [ats_pkg::WORD_W-1:0]  i_key,
    input  logic signed [ats_pkg::WORD_W-1:0]  i_new_value,
    input  logic [ats_pkg::POS_W-1:0]          i_position,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [ats_pkg::MIDX_W-1:0]         o_match_index,
    output logic                               o_found,
    output logic [ats_pkg::STAT_W-1:0]         o_status,
    output logic                               o_last,
    output logic [ats_pkg::CNTF_W-1:0]         o_entry_count,
    output logic [ats_pkg::CNTF_W-1:0]         o_replaced_count
);

    ats_pkg::t_state                    r_state, n_state;
    logic [ats_pkg::CNT_W-1:0]          r_count, n_count;
    logic [ats_pkg::ADDR_W-1:0]         r_idx, n_idx;
    ats_pkg::t_req                      r_kind, n_kind;
    logic signed [ats_pkg::WORD_W-1:0]  r_key, n_key;
    logic signed [ats_pkg::WORD_W-1:0]  r_nv, n_nv;
    logic [ats_pkg::POS_W-1:0]          r_pos, n_pos;
    ats_pkg::t_status                   r_status, n_status;
    logic [ats_pkg::CNT_W-1:0]          r_rep, n_rep;
    logic                               r_pend_v, n_pend_v;
    logic [ats_pkg::ADDR_W-1:0]         r_pend_idx, n_pend_idx;

    logic                               wr_en;
    logic [ats_pkg::ADDR_W-1:0]         wr_addr;
    logic signed [ats_pkg::WORD_W-1:0]  wr_data;
    logic                               rd_en;
    logic [ats_pkg::ADDR_W-1:0]         rd_addr;
    logic signed [ats_pkg::WORD_W-1:0]  rd_data;

    logic                               push;
    logic                               out_ready;
    ats_pkg::t_res                      res;
    ats_pkg::t_res                      out_res;

    logic                               hit;
    logic                               end_scan;
    logic                               adv;

    ats_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    ats_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (res),
        .o_ready (out_ready),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (out_res)
    );

    assign o_match_index    = out_res.match_index;
    assign o_found          = out_res.found;
    assign o_status         = out_res.status;
    assign o_last           = out_res.last;
    assign o_entry_count    = out_res.entry_count;
    assign o_replaced_count = out_res.replaced_count;

    assign o_in_stall = (r_state != ats_pkg::S_IDLE);

    assign hit      = (rd_data == r_key);
    assign end_scan = ((ats_pkg::CNT_W'(r_idx) + ats_pkg::CNT_W'(1)) == r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ats_pkg::S_IDLE;
            r_count  <= '0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_kind     <= n_kind;
        r_key      <= n_key;
        r_nv       <= n_nv;
        r_pos      <= n_pos;
        r_status   <= n_status;
        r_rep      <= n_rep;
        r_pend_idx <= n_pend_idx;
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_kind     = r_kind;
        n_key      = r_key;
        n_nv       = r_nv;
        n_pos      = r_pos;
        n_status   = r_status;
        n_rep      = r_rep;
        n_pend_v   = r_pend_v;
        n_pend_idx = r_pend_idx;
        wr_en      = 1'b0;
        wr_addr    = r_idx;
        wr_data    = r_nv;
        rd_en      = 1'b0;
        rd_addr    = r_idx;
        push       = 1'b0;
        res        = '0;
        adv        = 1'b1;

        unique case (r_state)
            ats_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_kind   = ats_pkg::t_req'(i_req_type);
                    n_key    = i_key;
                    n_nv     = i_new_value;
                    n_pos    = i_position;
                    n_status = ats_pkg::ST_OK;
                    n_rep    = '0;
                    n_pend_v = 1'b0;
                    n_idx    = '0;
                    n_state  = ats_pkg::S_DONE;
                    unique case (ats_pkg::t_req'(i_req_type))
                        ats_pkg::REQ_APPEND: begin
                            if (r_count >= ats_pkg::CNT_W'(ats_pkg::DEPTH)) begin
                                n_status = ats_pkg::ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = r_count[ats_pkg::ADDR_W-1:0];
                                wr_data = i_new_value;
                                n_count = r_count + 1'b1;
                            end
                        end
                        ats_pkg::REQ_SEARCH, ats_pkg::REQ_REPLACE: begin
                            if (r_count != '0) begin
                                n_state = ats_pkg::S_RD;
                            end
                        end
                        ats_pkg::REQ_INSERT: begin
                            if (i_position > ats_pkg::POS_W'(r_count)) begin
                                n_status = ats_pkg::ST_RANGE;
                            end else if (r_count >= ats_pkg::CNT_W'(ats_pkg::DEPTH)) begin
                                n_status = ats_pkg::ST_FULL;
                            end else if (i_position == ats_pkg::POS_W'(r_count)) begin
                                n_state = ats_pkg::S_PUT;
                            end else begin
                                n_idx   = r_count[ats_pkg::ADDR_W-1:0];
                                n_state = ats_pkg::S_RD;
                            end
                        end
                        ats_pkg::REQ_DELETE: begin
                            if (i_position >= ats_pkg::POS_W'(r_count)) begin
                                n_status = ats_pkg::ST_RANGE;
                            end else if (i_position
                                         == ats_pkg::POS_W'(r_count - 1'b1)) begin
                                n_count = r_count - 1'b1;
                            end else begin
                                n_idx   = i_position[ats_pkg::ADDR_W-1:0];
                                n_state = ats_pkg::S_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ats_pkg::S_RD: begin
                rd_en = 1'b1;
                unique case (r_kind)
                    ats_pkg::REQ_SEARCH, ats_pkg::REQ_REPLACE: begin
                        rd_addr = r_idx;
                        n_state = ats_pkg::S_CMP;
                    end
                    ats_pkg::REQ_INSERT: begin
                        rd_addr = r_idx - 1'b1;
                        n_state = ats_pkg::S_MOVE;
                    end
                    ats_pkg::REQ_DELETE: begin
                        rd_addr = r_idx + 1'b1;
                        n_state = ats_pkg::S_MOVE;
                    end
                    default: begin
                        n_state = ats_pkg::S_DONE;
                    end
                endcase
            end
            ats_pkg::S_CMP: begin
                if (r_kind == ats_pkg::REQ_REPLACE) begin
                    if (hit) begin
                        wr_en   = 1'b1;
                        wr_addr = r_idx;
                        wr_data = r_nv;
                        n_rep   = r_rep + 1'b1;
                    end
                end else if (hit) begin
                    if (r_pend_v) begin
                        push                = 1'b1;
                        res.match_index     = ats_pkg::MIDX_W'(r_pend_idx);
                        res.found           = 1'b1;
                        res.status          = ats_pkg::ST_OK;
                        res.last            = 1'b0;
                        res.entry_count     = ats_pkg::CNTF_W'(r_count);
                        adv                 = out_ready;
                    end
                    if (adv) begin
                        n_pend_v   = 1'b1;
                        n_pend_idx = r_idx;
                    end
                end
                if (adv) begin
                    if (end_scan) begin
                        n_state = ats_pkg::S_DONE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ats_pkg::S_RD;
                    end
                end
            end
            ats_pkg::S_MOVE: begin
                wr_en   = 1'b1;
                wr_addr = r_idx;
                wr_data = rd_data;
                if (r_kind == ats_pkg::REQ_INSERT) begin
                    if ((r_idx - 1'b1) == r_pos[ats_pkg::ADDR_W-1:0]) begin
                        n_state = ats_pkg::S_PUT;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = ats_pkg::S_RD;
                    end
                end else begin
                    if ((ats_pkg::CNT_W'(r_idx) + ats_pkg::CNT_W'(2)) == r_count) begin
                        n_count = r_count - 1'b1;
                        n_state = ats_pkg::S_DONE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ats_pkg::S_RD;
                    end
                end
            end
            ats_pkg::S_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_pos[ats_pkg::ADDR_W-1:0];
                wr_data = r_nv;
                n_count = r_count + 1'b1;
                n_state = ats_pkg::S_DONE;
            end
            ats_pkg::S_DONE: begin
                push        = 1'b1;
                res.status  = r_status;
                res.last    = 1'b1;
                res.entry_count = ats_pkg::CNTF_W'(r_count);
                if (r_kind == ats_pkg::REQ_SEARCH && r_pend_v) begin
                    res.match_index = ats_pkg::MIDX_W'(r_pend_idx);
                    res.found       = 1'b1;
                end
                if (r_kind == ats_pkg::REQ_REPLACE) begin
                    res.replaced_count = ats_pkg::CNTF_W'(r_rep);
                end
                if (out_ready) begin
                    n_state = ats_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ats_pkg::S_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ats_pkg::CNT_W'(ats_pkg::DEPTH))
        else $error("entry count exceeds table depth");

    a_found_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> o_status == ats_pkg::ST_OK && o_replaced_count == '0)
        else $error("search match carries error status or replace count");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("block not busy after taking an item");

    a_push_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !out_ready && r_state == ats_pkg::S_DONE |=> r_state == ats_pkg::S_DONE)
        else $error("final result dropped while output stalled");

endmodule

### src/ats_mem.sv
module ats_mem (
    input  logic                              i_clk,
    input  logic                              i_wr_en,
    input  logic [ats_pkg::ADDR_W-1:0]        i_wr_addr,
    input  logic signed [ats_pkg::WORD_W-1:0] i_wr_data,
    input  logic                              i_rd_en,
    input  logic [ats_pkg::ADDR_W-1:0]        i_rd_addr,
    output logic signed [ats_pkg::WORD_W-1:0] o_rd_data
);

    logic signed [ats_pkg::WORD_W-1:0] r_mem [ats_pkg::DEPTH];
    logic signed [ats_pkg::WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/ats_outq.sv
module ats_outq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ats_pkg::t_res i_res,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_stall,
    output ats_pkg::t_res o_res
);

    logic          r_valid;
    ats_pkg::t_res r_res;

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && o_ready) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ats_pkg::REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
    localparam logic [ats_pkg::REQ_W-1:0] REQ_UNUSED_HI = 3'd7;
    localparam logic signed [ats_pkg::WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [ats_pkg::WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
    localparam int POS_MAX = (1 << ats_pkg::POS_W) - 1;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 2 * ats_pkg::DEPTH + 20;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS = 46;

    typedef struct {
        logic [ats_pkg::REQ_W-1:0]         kind;
        logic signed [ats_pkg::WORD_W-1:0] key;
        logic signed [ats_pkg::WORD_W-1:0] nv;
        logic [ats_pkg::POS_W-1:0]         pos;
        int                                reps;
        bit                                typed;
        ats_pkg::t_res                     res;
    } t_plan_row;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_in_valid = 1'b0;
    logic                                 o_in_stall;
    logic [ats_pkg::REQ_W-1:0]            i_req_type = '0;
    logic signed [ats_pkg::WORD_W-1:0]    i_key = '0;
    logic signed [ats_pkg::WORD_W-1:0]    i_new_value = '0;
    logic [ats_pkg::POS_W-1:0]            i_position = '0;
    logic                                 o_out_valid;
    logic                                 i_out_stall = 1'b0;
    logic [ats_pkg::MIDX_W-1:0]           o_match_index;
    logic                                 o_found;
    logic [ats_pkg::STAT_W-1:0]           o_status;
    logic                                 o_last;
    logic [ats_pkg::CNTF_W-1:0]           o_entry_count;
    logic [ats_pkg::CNTF_W-1:0]           o_replaced_count;

    logic signed [ats_pkg::WORD_W-1:0]    mirror_words [ats_pkg::DEPTH];
    int                                   mirror_count = 0;
    ats_pkg::t_res                        pending_results [$];
    t_plan_row                            plan [$];
    int                                   errors = 0;
    int                                   quiet_cycles = 0;
    bit                                   in_burst = 1'b0;
    bit                                   out_burst = 1'b0;

    array_table_search_insert_delete dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_key            (i_key),
        .i_new_value      (i_new_value),
        .i_position       (i_position),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_match_index    (o_match_index),
        .o_found          (o_found),
        .o_status         (o_status),
        .o_last           (o_last),
        .o_entry_count    (o_entry_count),
        .o_replaced_count (o_replaced_count)
    );

    always #2 i_clk = ~i_clk;

    function automatic ats_pkg::t_res table_result(ats_pkg::t_status st, int cnt,
                                                   int replaced);
        ats_pkg::t_res r;
        r.match_index    = '0;
        r.found          = 1'b0;
        r.status         = st;
        r.last           = 1'b1;
        r.entry_count    = ats_pkg::CNTF_W'(cnt);
        r.replaced_count = ats_pkg::CNTF_W'(replaced);
        return r;
    endfunction

    function automatic void predict_request(logic [ats_pkg::REQ_W-1:0] kind,
                                            logic signed [ats_pkg::WORD_W-1:0] key,
                                            logic signed [ats_pkg::WORD_W-1:0] nv,
                                            logic [ats_pkg::POS_W-1:0] pos);
        int hits [$];
        int changed;
        int p;
        ats_pkg::t_res r;
        p = int'(pos);
        case (kind)
            ats_pkg::REQ_APPEND: begin
                if (mirror_count >= ats_pkg::DEPTH) begin
                    pending_results.push_back(
                        table_result(ats_pkg::ST_FULL, mirror_count, 0));
                end else begin
                    mirror_words[mirror_count] = nv;
                    mirror_count++;
                    pending_results.push_back(
                        table_result(ats_pkg::ST_OK, mirror_count, 0));
                end
            end
            ats_pkg::REQ_SEARCH: begin
                for (int i = 0; i < mirror_count; i++)
                    if (mirror_words[i] == key) hits.push_back(i);
                if (hits.size() == 0) begin
                    pending_results.push_back(
                        table_result(ats_pkg::ST_OK, mirror_count, 0));
                end else begin
                    foreach (hits[j]) begin
                        r = table_result(ats_pkg::ST_OK, mirror_count, 0);
                        r.match_index = ats_pkg::MIDX_W'(hits[j]);
                        r.found = 1'b1;
                        r.last = (j == hits.size() - 1);
                        pending_results.push_back(r);
                    end
                end
            end
            ats_pkg::REQ_REPLACE: begin
                changed = 0;
                for (int i = 0; i < mirror_count; i++)
                    if (mirror_words[i] == key) begin
                        mirror_words[i] = nv;
                        changed++;
                    end
                pending_results.push_back(
                    table_result(ats_pkg::ST_OK, mirror_count, changed));
            end
            ats_pkg::REQ_INSERT: begin
                if (p > mirror_count) begin
                    pending_results.push_back(
                        table_result(ats_pkg::ST_RANGE, mirror_count, 0));
                end else if (mirror_count >= ats_pkg::DEPTH) begin
                    pending_results.push_back(
                        table_result(ats_pkg::ST_FULL, mirror_count, 0));
                end else begin
                    for (int i = mirror_count; i > p; i--)
                        mirror_words[i] = mirror_words[i-1];
                    mirror_words[p] = nv;
                    mirror_count++;
                    pending_results.push_back(
                        table_result(ats_pkg::ST_OK, mirror_count, 0));
                end
            end
            ats_pkg::REQ_DELETE: begin
                if (p >= mirror_count) begin
                    pending_results.push_back(
                        table_result(ats_pkg::ST_RANGE, mirror_count, 0));
                end else begin
                    for (int i = p; i + 1 < mirror_count; i++)
                        mirror_words[i] = mirror_words[i+1];
                    mirror_count--;
                    pending_results.push_back(
                        table_result(ats_pkg::ST_OK, mirror_count, 0));
                end
            end
            default: begin
                pending_results.push_back(table_result(ats_pkg::ST_OK, mirror_count, 0));
            end
        endcase
    endfunction

    function automatic int draw_wait(bit burst);
        return burst ? 0 : $urandom_range(0, 8);
    endfunction

    task automatic send_item(logic [ats_pkg::REQ_W-1:0] kind,
                             logic signed [ats_pkg::WORD_W-1:0] key,
                             logic signed [ats_pkg::WORD_W-1:0] nv,
                             logic [ats_pkg::POS_W-1:0] pos,
                             bit typed, ats_pkg::t_res res);
        int gap;
        gap = draw_wait(in_burst);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req_type  = kind;
        i_key       = key;
        i_new_value = nv;
        i_position  = pos;
        i_in_valid  = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        predict_request(kind, key, nv, pos);
        if (typed) pending_results[pending_results.size()-1] = res;
        @(negedge i_clk);
    endtask

    task automatic drain_pause();
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic add_row(logic [ats_pkg::REQ_W-1:0] kind,
                           logic signed [ats_pkg::WORD_W-1:0] key,
                           logic signed [ats_pkg::WORD_W-1:0] nv, int pos, int reps,
                           bit typed, ats_pkg::t_status st, int cnt);
        t_plan_row row;
        row.kind  = kind;
        row.key   = key;
        row.nv    = nv;
        row.pos   = ats_pkg::POS_W'(pos);
        row.reps  = reps;
        row.typed = typed;
        row.res   = table_result(st, cnt, 0);
        plan.push_back(row);
    endtask

    function automatic logic signed [ats_pkg::WORD_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            case ($urandom_range(0, 4))
                0: return 0;
                1: return -1;
                2: return WORD_MIN;
                3: return WORD_MAX;
                default: return $urandom_range(0, 7);
            endcase
        end
        if (r < 70 && mirror_count > 0)
            return mirror_words[$urandom_range(0, mirror_count - 1)];
        return $urandom;
    endfunction

    function automatic logic [ats_pkg::POS_W-1:0] pick_pos(bit for_insert);
        int r;
        int top;
        r = $urandom_range(0, 99);
        top = for_insert ? mirror_count : mirror_count - 1;
        if (r < 80 && top >= 0) return ats_pkg::POS_W'($urandom_range(0, top));
        if (r < 90) return ats_pkg::POS_W'(mirror_count + (for_insert ? 1 : 0));
        return ats_pkg::POS_W'($urandom_range(0, POS_MAX));
    endfunction

    function automatic logic [ats_pkg::REQ_W-1:0] pick_kind(bit grow);
        int r;
        r = $urandom_range(0, 99);
        if (grow) begin
            if (r < 30) return ats_pkg::REQ_APPEND;
            if (r < 55) return ats_pkg::REQ_INSERT;
            if (r < 65) return ats_pkg::REQ_DELETE;
            if (r < 85) return ats_pkg::REQ_SEARCH;
            if (r < 95) return ats_pkg::REQ_REPLACE;
        end else begin
            if (r < 10) return ats_pkg::REQ_APPEND;
            if (r < 20) return ats_pkg::REQ_INSERT;
            if (r < 60) return ats_pkg::REQ_DELETE;
            if (r < 85) return ats_pkg::REQ_SEARCH;
            if (r < 95) return ats_pkg::REQ_REPLACE;
        end
        return ats_pkg::REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
    endfunction

    task automatic report_field(string name, int exp_v, int got_v);
        $display("%0t %s mismatch: expected %0d, got %0d", $time, name, exp_v, got_v);
        errors++;
    endtask

    task automatic check_result();
        ats_pkg::t_res exp_r;
        if (pending_results.size() == 0) begin
            $display("%0t unexpected item: index %0d found %0d status %0d last %0d count %0d",
                     $time, o_match_index, o_found, o_status, o_last, o_entry_count);
            errors++;
            return;
        end
        exp_r = pending_results.pop_front();
        if (o_match_index !== exp_r.match_index)
            report_field("match_index", exp_r.match_index, o_match_index);
        if (o_found !== exp_r.found)
            report_field("found", exp_r.found, o_found);
        if (o_status !== exp_r.status)
            report_field("status", exp_r.status, o_status);
        if (o_last !== exp_r.last)
            report_field("last", exp_r.last, o_last);
        if (o_entry_count !== exp_r.entry_count)
            report_field("entry_count", exp_r.entry_count, o_entry_count);
        if (o_replaced_count !== exp_r.replaced_count)
            report_field("replaced_count", exp_r.replaced_count, o_replaced_count);
    endtask

    initial begin
        int n;
        wait (i_rst_n);
        forever begin
            n = draw_wait(out_burst);
            if (n > 0) begin
                i_out_stall = 1'b1;
                repeat (n) @(negedge i_clk);
                i_out_stall = 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
            check_result();
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        logic [ats_pkg::REQ_W-1:0] kind;
        add_row(ats_pkg::REQ_SEARCH,  0, 0, 0, 1, 1, ats_pkg::ST_OK, 0);
        add_row(ats_pkg::REQ_DELETE,  0, 0, 0, 1, 1, ats_pkg::ST_RANGE, 0);
        add_row(ats_pkg::REQ_INSERT,  0, 0, 1, 1, 1, ats_pkg::ST_RANGE, 0);
        add_row(ats_pkg::REQ_REPLACE, 0, 5, 0, 1, 1, ats_pkg::ST_OK, 0);
        add_row(ats_pkg::REQ_APPEND,  0, WORD_MIN, 0, 1, 1, ats_pkg::ST_OK, 1);
        add_row(ats_pkg::REQ_APPEND,  0, WORD_MAX, 0, 1, 1, ats_pkg::ST_OK, 2);
        add_row(ats_pkg::REQ_INSERT,  0, -1, 0, 1, 1, ats_pkg::ST_OK, 3);
        add_row(ats_pkg::REQ_INSERT,  0, WORD_MIN, 3, 1, 1, ats_pkg::ST_OK, 4);
        add_row(ats_pkg::REQ_SEARCH,  WORD_MIN, 0, 0, 1, 0, ats_pkg::ST_OK, 0);
        add_row(ats_pkg::REQ_REPLACE, WORD_MIN, 0, 0, 1, 0, ats_pkg::ST_OK, 0);
        add_row(REQ_UNUSED_HI, WORD_MAX, WORD_MIN, POS_MAX, 1, 1, ats_pkg::ST_OK, 4);
        add_row(ats_pkg::REQ_DELETE,  0, 0, 4, 1, 1, ats_pkg::ST_RANGE, 4);
        add_row(ats_pkg::REQ_DELETE,  0, 0, 0, 1, 1, ats_pkg::ST_OK, 3);
        add_row(ats_pkg::REQ_INSERT,  0, 0, POS_MAX, 1, 1, ats_pkg::ST_RANGE, 3);
        add_row(ats_pkg::REQ_SEARCH,  WORD_MAX, 0, 0, 1, 0, ats_pkg::ST_OK, 0);
        add_row(ats_pkg::REQ_APPEND,  0, 0, 0, ats_pkg::DEPTH - 3, 0, ats_pkg::ST_OK, 0);
        add_row(ats_pkg::REQ_APPEND,  0, 1, 0, 1, 1, ats_pkg::ST_FULL, ats_pkg::DEPTH);
        add_row(ats_pkg::REQ_INSERT,  0, 1, 0, 1, 1, ats_pkg::ST_FULL, ats_pkg::DEPTH);
        add_row(ats_pkg::REQ_INSERT,  0, 1, ats_pkg::DEPTH, 1, 1, ats_pkg::ST_FULL,
                ats_pkg::DEPTH);
        add_row(ats_pkg::REQ_INSERT,  0, 1, ats_pkg::DEPTH + 1, 1, 1, ats_pkg::ST_RANGE,
                ats_pkg::DEPTH);
        add_row(ats_pkg::REQ_SEARCH,  0, 0, 0, 1, 0, ats_pkg::ST_OK, 0);
        add_row(ats_pkg::REQ_REPLACE, 0, 9, 0, 1, 0, ats_pkg::ST_OK, 0);
        add_row(ats_pkg::REQ_SEARCH,  9, 0, 0, 1, 0, ats_pkg::ST_OK, 0);
        add_row(ats_pkg::REQ_DELETE,  0, 0, ats_pkg::DEPTH - 1, 1, 1, ats_pkg::ST_OK,
                ats_pkg::DEPTH - 1);
        add_row(ats_pkg::REQ_DELETE,  0, 0, ats_pkg::DEPTH - 1, 1, 1, ats_pkg::ST_RANGE,
                ats_pkg::DEPTH - 1);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[k])
            repeat (plan[k].reps)
                send_item(plan[k].kind, plan[k].key, plan[k].nv, plan[k].pos,
                          plan[k].typed, plan[k].res);
        drain_pause();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            in_burst  = (p == 2);
            out_burst = (p == 2 || p == 4);
            repeat (PHASE_ITEMS) begin
                kind = pick_kind(p % 2 == 0);
                send_item(kind, pick_word(), pick_word(),
                          pick_pos(kind != ats_pkg::REQ_DELETE),
                          1'b0, table_result(ats_pkg::ST_OK, 0, 0));
            end
            drain_pause();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
